// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the tile row decoder RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define PTRR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the module's clk_i / rst_ni
`define PTRR_ASSERT(lbl, prop, msg) \
  `PTRR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/ptrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrr_pkg
// Types, constants and colour helpers for the planar tile row decoder
// ----------------------------------------------------------------------------
package ptrr_pkg;

  localparam int unsigned PalAw     = 5;
  localparam int unsigned PalDepth  = 1 << PalAw;
  localparam int unsigned ColW      = 15;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned NumPix    = 8;
  localparam int unsigned ColX      = 3;
  localparam int unsigned RowW      = 3;
  localparam int unsigned PixW      = 32;
  localparam int unsigned NumBanks  = NumPix / 2;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaClear  = 8'h00;

  typedef enum logic {
    CmdPalWrite = 1'b0,
    CmdDecode   = 1'b1
  } cmd_e;

  typedef logic [ColW-1:0]  rgb555_t;
  typedef logic [IdxW-1:0]  cidx_t;
  typedef logic [PalAw-1:0] pal_addr_t;
  typedef logic [PixW-1:0]  argb_t;

  // widen 5-bit channels to 8 bits, low bits zero
  function automatic argb_t to_argb(rgb555_t col, logic opaque);
    logic [7:0] a;
    a = opaque ? AlphaOpaque : AlphaClear;
    return {a, col[14:10], 3'b000, col[9:5], 3'b000, col[4:0], 3'b000};
  endfunction

endpackage

// ===== rtl/core/planar_tile_row_to_rgba.sv =====
// ----------------------------------------------------------------------------
// planar_tile_row_to_rgba
// Planar 4bpp tile row decoder: 32-entry RGB555 palette, eight ARGB pixels
// per row beat with horizontal and vertical mirroring
// ----------------------------------------------------------------------------
// channel | handshake               | payload
// --------+-------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o | command, palette write, planes, row, flags
// out     | out_valid_o/out_stall_i | target_row, pixel_x0..pixel_x7
//
// one beat per cycle unless in_stall_o is high; a row beat passes stages 1, 2 and 3 before it leaves
// palette writes are applied when accepted and produce no output beat
// palette store is in four banked copies of two read ports each, read in stage 2
// after reset every palette entry reads as zero through per-entry valid flags
// out_stall_i holds a full stage 3; an earlier stage waits only while every
// stage after it is full; in_stall_o rises when stage 1 cannot advance
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_tile_row_to_rgba (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [4:0]  palette_addr_i,
  input  logic [14:0] palette_value_i,
  input  logic [7:0]  plane0_bits_i,
  input  logic [7:0]  plane1_bits_i,
  input  logic [7:0]  plane2_bits_i,
  input  logic [7:0]  plane3_bits_i,
  input  logic [2:0]  source_row_i,
  input  logic        palette_select_i,
  input  logic        hflip_i,
  input  logic        vflip_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_row_o,
  output logic [31:0] pixel_x0_o,
  output logic [31:0] pixel_x1_o,
  output logic [31:0] pixel_x2_o,
  output logic [31:0] pixel_x3_o,
  output logic [31:0] pixel_x4_o,
  output logic [31:0] pixel_x5_o,
  output logic [31:0] pixel_x6_o,
  output logic [31:0] pixel_x7_o
);
  import ptrr_pkg::*;

  logic adv1, adv2, adv3;
  logic in_acc, pal_we, dec_acc;

  logic [ColX-1:0] sh_w [NumPix];
  cidx_t           idx_d [NumPix];

  logic            s1_vld_q;
  cidx_t           s1_idx_q [NumPix];
  logic            s1_sel_q;
  logic [RowW-1:0] s1_row_q;

  logic [PalDepth-1:0] pal_vld_q;

  logic            s2_vld_q;
  logic [RowW-1:0] s2_row_q;
  logic            s2_opq_q [NumPix];
  logic            s2_hit_q [NumPix];
  rgb555_t         s2_col [NumPix];

  logic            s3_vld_q;
  logic [RowW-1:0] s3_row_q;
  argb_t           s3_pix_q [NumPix];

  // handshake chain
  assign adv3       = !s3_vld_q || !out_stall_i;
  assign adv2       = !s2_vld_q || adv3;
  assign adv1       = !s1_vld_q || adv2;
  assign in_stall_o = !adv1;
  assign in_acc     = in_valid_i && adv1;
  assign pal_we     = in_acc && (command_i == CmdPalWrite);
  assign dec_acc    = in_acc && (command_i == CmdDecode);

  // gather colour indices at their output columns
  always_comb begin
    for (int c = 0; c < NumPix; c++) begin
      sh_w[c]  = hflip_i ? ColX'(c) : ColX'(NumPix - 1 - c);
      idx_d[c] = {plane3_bits_i[sh_w[c]], plane2_bits_i[sh_w[c]],
                  plane1_bits_i[sh_w[c]], plane0_bits_i[sh_w[c]]};
    end
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv1) begin
      s1_vld_q <= dec_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_acc) begin
      s1_idx_q <= idx_d;
      s1_sel_q <= palette_select_i;
      s1_row_q <= vflip_i ? RowW'(NumPix - 1) - source_row_i : source_row_i;
    end
  end

  // palette entry valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (pal_we) begin
      pal_vld_q[palette_addr_i] <= 1'b1;
    end
  end

  // stage 2: banked palette read
  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    rgb555_t   mem [PalDepth];
    rgb555_t   rd_q [2];
    pal_addr_t ra0, ra1;

    assign ra0 = {s1_sel_q, s1_idx_q[2*b]};
    assign ra1 = {s1_sel_q, s1_idx_q[2*b+1]};

    always_ff @(posedge clk_i) begin
      if (pal_we) begin
        mem[palette_addr_i] <= palette_value_i;
      end
      if (adv2) begin
        rd_q[0] <= mem[ra0];
        rd_q[1] <= mem[ra1];
      end
    end

    assign s2_col[2*b]   = rd_q[0];
    assign s2_col[2*b+1] = rd_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv2) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_row_q <= s1_row_q;
      for (int c = 0; c < NumPix; c++) begin
        s2_opq_q[c] <= (s1_idx_q[c] != '0);
        s2_hit_q[c] <= pal_vld_q[{s1_sel_q, s1_idx_q[c]}];
      end
    end
  end

  // stage 3: colour expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv3) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_vld_q) begin
      s3_row_q <= s2_row_q;
      for (int c = 0; c < NumPix; c++) begin
        s3_pix_q[c] <= to_argb(s2_hit_q[c] ? s2_col[c] : '0, s2_opq_q[c]);
      end
    end
  end

  assign out_valid_o  = s3_vld_q;
  assign target_row_o = s3_row_q;
  assign pixel_x0_o   = s3_pix_q[0];
  assign pixel_x1_o   = s3_pix_q[1];
  assign pixel_x2_o   = s3_pix_q[2];
  assign pixel_x3_o   = s3_pix_q[3];
  assign pixel_x4_o   = s3_pix_q[4];
  assign pixel_x5_o   = s3_pix_q[5];
  assign pixel_x6_o   = s3_pix_q[6];
  assign pixel_x7_o   = s3_pix_q[7];

  `PTRR_ASSERT(a_stall_needs_s1, in_stall_o |-> s1_vld_q, "input stalled with stage 1 empty")
  `PTRR_ASSERT(a_write_sets_flag, pal_we |=> pal_vld_q[$past(palette_addr_i)], "palette flag not set")
  `PTRR_ASSERT(a_s2_to_s3, (s2_vld_q && adv3) |=> s3_vld_q, "row beat lost between stages 2 and 3")
  `PTRR_ASSERT(a_out_held, (s3_vld_q && out_stall_i) |=> s3_vld_q, "stalled output beat dropped")

endmodule
